FILE: rtl/biq_pkg.sv
// Shared types, codes and microcode for the biquad filter block.
package biq_pkg;

  // Fixed internal widths
  localparam int STATE_W   = 32;
  localparam int ACC_W     = 64;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 3;

  // Last step index of the longest program (transposed direct form)
  localparam logic [STEP_W-1:0] STEP_MAX = 4'd13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRUCTURE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A0        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A1        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A2        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B1        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_B2        = 3'd5;

  // Filter structures
  localparam logic [1:0] ST_DF1 = 2'd0;  // direct form I
  localparam logic [1:0] ST_DF2 = 2'd1;  // canonical direct form II
  localparam logic [1:0] ST_TDF = 2'd2;  // transposed direct form
  localparam logic [1:0] ST_TCF = 2'd3;  // transposed canonical form
  localparam logic [1:0] STRUCT_RESET = ST_TCF;

  // Input op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Multiplier coefficient select
  localparam logic [2:0] CS_A0  = 3'd0;
  localparam logic [2:0] CS_A1  = 3'd1;
  localparam logic [2:0] CS_A2  = 3'd2;
  localparam logic [2:0] CS_B1  = 3'd3;
  localparam logic [2:0] CS_B2  = 3'd4;
  localparam logic [2:0] CS_ONE = 3'd5;  // unity gain: scales a plain term

  // Multiplier data select
  localparam logic [2:0] DS_X   = 3'd0;
  localparam logic [2:0] DS_W   = 3'd1;
  localparam logic [2:0] DS_Y   = 3'd2;
  localparam logic [2:0] DS_XD1 = 3'd3;
  localparam logic [2:0] DS_XD2 = 3'd4;
  localparam logic [2:0] DS_YD1 = 3'd5;
  localparam logic [2:0] DS_YD2 = 3'd6;

  // Accumulator operations on the registered product
  localparam logic [2:0] AC_NONE  = 3'd0;
  localparam logic [2:0] AC_LOAD  = 3'd1;
  localparam logic [2:0] AC_LOADN = 3'd2;
  localparam logic [2:0] AC_ADD   = 3'd3;
  localparam logic [2:0] AC_SUB   = 3'd4;

  // Destination of the rounded accumulator value
  localparam logic [3:0] FD_NONE = 4'd0;
  localparam logic [3:0] FD_W    = 4'd1;
  localparam logic [3:0] FD_Y    = 4'd2;
  localparam logic [3:0] FD_XD1  = 4'd3;
  localparam logic [3:0] FD_XD2  = 4'd4;
  localparam logic [3:0] FD_YD1  = 4'd5;
  localparam logic [3:0] FD_YD2  = 4'd6;
  localparam logic [3:0] FD_DF1  = 4'd7;  // y out plus direct form I delay shift
  localparam logic [3:0] FD_DF2  = 4'd8;  // y out plus form II delay shift

  typedef struct packed {
    logic [2:0] coef_sel;
    logic [2:0] data_sel;
    logic [2:0] acc_op;
    logic [3:0] fin_dest;
    logic       last;
  } biq_uop_t;

  typedef struct packed {
    logic load;   // sample transfer: latch x, start program
    logic clear;  // clear transfer: zero the delay registers
  } biq_req_t;

  localparam biq_uop_t UOP_END = '{coef_sel: CS_ONE, data_sel: DS_X, acc_op: AC_NONE,
                                   fin_dest: FD_NONE, last: 1'b1};

  function automatic biq_uop_t biq_mk(logic [2:0] cs, logic [2:0] ds, logic [2:0] ac,
                                      logic [3:0] fd, logic lst);
    biq_uop_t u;
    u.coef_sel = cs;
    u.data_sel = ds;
    u.acc_op   = ac;
    u.fin_dest = fd;
    u.last     = lst;
    return u;
  endfunction

  // Microcode. Each step: multiply into product reg, accumulate previous
  // product, round the accumulator value from the previous step.
  function automatic biq_uop_t biq_ucode(logic [1:0] structure, logic [STEP_W-1:0] step);
    biq_uop_t u;
    u = UOP_END;
    case (structure)
      ST_DF1: begin
        case (step)
          4'd0: u = biq_mk(CS_A0,  DS_X,   AC_NONE, FD_NONE, 1'b0);
          4'd1: u = biq_mk(CS_A1,  DS_XD1, AC_LOAD, FD_NONE, 1'b0);
          4'd2: u = biq_mk(CS_A2,  DS_XD2, AC_ADD,  FD_NONE, 1'b0);
          4'd3: u = biq_mk(CS_B1,  DS_YD1, AC_ADD,  FD_NONE, 1'b0);
          4'd4: u = biq_mk(CS_B2,  DS_YD2, AC_SUB,  FD_NONE, 1'b0);
          4'd5: u = biq_mk(CS_ONE, DS_X,   AC_SUB,  FD_NONE, 1'b0);
          4'd6: u = biq_mk(CS_ONE, DS_X,   AC_NONE, FD_DF1,  1'b1);
          default: u = UOP_END;
        endcase
      end
      ST_DF2: begin
        case (step)
          4'd0: u = biq_mk(CS_ONE, DS_X,   AC_NONE, FD_NONE, 1'b0);
          4'd1: u = biq_mk(CS_B1,  DS_XD1, AC_LOAD, FD_NONE, 1'b0);
          4'd2: u = biq_mk(CS_B2,  DS_XD2, AC_SUB,  FD_NONE, 1'b0);
          4'd3: u = biq_mk(CS_A1,  DS_XD1, AC_SUB,  FD_NONE, 1'b0);
          4'd4: u = biq_mk(CS_A2,  DS_XD2, AC_LOAD, FD_W,    1'b0);
          4'd5: u = biq_mk(CS_A0,  DS_W,   AC_ADD,  FD_NONE, 1'b0);
          4'd6: u = biq_mk(CS_ONE, DS_X,   AC_ADD,  FD_NONE, 1'b0);
          4'd7: u = biq_mk(CS_ONE, DS_X,   AC_NONE, FD_DF2,  1'b1);
          default: u = UOP_END;
        endcase
      end
      ST_TDF: begin
        case (step)
          4'd0:  u = biq_mk(CS_ONE, DS_X,   AC_NONE,  FD_NONE, 1'b0);
          4'd1:  u = biq_mk(CS_ONE, DS_YD1, AC_LOAD,  FD_NONE, 1'b0);
          4'd2:  u = biq_mk(CS_ONE, DS_X,   AC_ADD,   FD_NONE, 1'b0);
          4'd3:  u = biq_mk(CS_ONE, DS_X,   AC_NONE,  FD_W,    1'b0);
          4'd4:  u = biq_mk(CS_A0,  DS_W,   AC_NONE,  FD_NONE, 1'b0);
          4'd5:  u = biq_mk(CS_ONE, DS_XD1, AC_LOAD,  FD_NONE, 1'b0);
          4'd6:  u = biq_mk(CS_ONE, DS_YD2, AC_ADD,   FD_NONE, 1'b0);
          4'd7:  u = biq_mk(CS_B1,  DS_W,   AC_LOAD,  FD_Y,    1'b0);
          4'd8:  u = biq_mk(CS_B2,  DS_W,   AC_SUB,   FD_NONE, 1'b0);
          4'd9:  u = biq_mk(CS_ONE, DS_XD2, AC_LOADN, FD_YD1,  1'b0);
          4'd10: u = biq_mk(CS_A1,  DS_W,   AC_LOAD,  FD_YD2,  1'b0);
          4'd11: u = biq_mk(CS_A2,  DS_W,   AC_ADD,   FD_NONE, 1'b0);
          4'd12: u = biq_mk(CS_ONE, DS_X,   AC_LOAD,  FD_XD1,  1'b0);
          4'd13: u = biq_mk(CS_ONE, DS_X,   AC_NONE,  FD_XD2,  1'b1);
          default: u = UOP_END;
        endcase
      end
      default: begin
        case (step)
          4'd0: u = biq_mk(CS_A0,  DS_X,   AC_NONE, FD_NONE, 1'b0);
          4'd1: u = biq_mk(CS_ONE, DS_XD1, AC_LOAD, FD_NONE, 1'b0);
          4'd2: u = biq_mk(CS_ONE, DS_X,   AC_ADD,  FD_NONE, 1'b0);
          4'd3: u = biq_mk(CS_A1,  DS_X,   AC_NONE, FD_Y,    1'b0);
          4'd4: u = biq_mk(CS_B1,  DS_Y,   AC_LOAD, FD_NONE, 1'b0);
          4'd5: u = biq_mk(CS_ONE, DS_XD2, AC_SUB,  FD_NONE, 1'b0);
          4'd6: u = biq_mk(CS_A2,  DS_X,   AC_ADD,  FD_NONE, 1'b0);
          4'd7: u = biq_mk(CS_B2,  DS_Y,   AC_LOAD, FD_XD1,  1'b0);
          4'd8: u = biq_mk(CS_ONE, DS_X,   AC_SUB,  FD_NONE, 1'b0);
          4'd9: u = biq_mk(CS_ONE, DS_X,   AC_NONE, FD_XD2,  1'b1);
          default: u = UOP_END;
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/biq_mac.sv
// Shared multiply-accumulate unit with round, shift and saturate.
module biq_mac
  import biq_pkg::*;
#(
  parameter int COEF_WIDTH = 24
) (
  input  logic                      clk_i,
  input  logic signed [COEF_WIDTH-1:0] coef_i,
  input  logic signed [STATE_W-1:0] data_i,
  input  logic [2:0]                acc_op_i,
  output logic signed [STATE_W-1:0] fin_o
);

  localparam int FRAC_W = COEF_WIDTH - 3;
  localparam int PROD_W = COEF_WIDTH + STATE_W;
  localparam logic signed [ACC_W:0] HALF = {{ACC_W{1'b0}}, 1'b1} << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext, acc_base;
  logic signed [ACC_W:0]    sum, rnd;
  logic signed [ACC_W-1:0]  rnd_sat, shifted;
  logic                     sub;

  // Product and accumulator registers
  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * data_i;
    acc_q  <= acc_d;
  end

  // Saturating accumulate of the registered product
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    acc_base = (acc_op_i == AC_LOAD || acc_op_i == AC_LOADN) ? '0 : acc_q;
    sub      = (acc_op_i == AC_SUB || acc_op_i == AC_LOADN);
    if (sub) begin
      sum = (ACC_W+1)'(acc_base) - (ACC_W+1)'(prod_ext);
    end else begin
      sum = (ACC_W+1)'(acc_base) + (ACC_W+1)'(prod_ext);
    end
    case (acc_op_i)
      AC_NONE: acc_d = acc_q;
      default: begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          acc_d = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
          acc_d = sum[ACC_W-1:0];
        end
      end
    endcase
  end

  // Round half up, arithmetic shift by the fraction bits, clamp to state width
  always_comb begin
    rnd = (ACC_W+1)'(acc_q) + HALF;
    rnd_sat = (rnd[ACC_W] != rnd[ACC_W-1]) ? ACC_MAX : rnd[ACC_W-1:0];
    shifted = rnd_sat >>> FRAC_W;
    if ((&shifted[ACC_W-1:STATE_W-1]) || !(|shifted[ACC_W-1:STATE_W-1])) begin
      fin_o = shifted[STATE_W-1:0];
    end else begin
      fin_o = shifted[ACC_W-1] ? ST_MIN : ST_MAX;
    end
  end

endmodule

FILE: rtl/biq_state.sv
// Working registers and delay line of the filter, with operand select.
module biq_state
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  biq_req_t                       req_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  biq_uop_t                       uop_i,
  input  logic signed [STATE_W-1:0]      fin_i,
  output logic signed [STATE_W-1:0]      data_o,
  output logic signed [STATE_W-1:0]      y_o
);

  logic signed [STATE_W-1:0] x_q, w_q, y_q;
  logic signed [STATE_W-1:0] xd1_q, xd2_q, yd1_q, yd2_q;
  logic                      y_wr;

  assign y_wr = (uop_i.fin_dest == FD_Y || uop_i.fin_dest == FD_DF1 ||
                 uop_i.fin_dest == FD_DF2);

  // Working values of the current sample
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      x_q <= STATE_W'(sample_i);
    end
    if (uop_i.fin_dest == FD_W) begin
      w_q <= fin_i;
    end
    if (y_wr) begin
      y_q <= fin_i;
    end
  end

  // Delay registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xd1_q <= '0;
      xd2_q <= '0;
      yd1_q <= '0;
      yd2_q <= '0;
    end else if (req_i.clear) begin
      xd1_q <= '0;
      xd2_q <= '0;
      yd1_q <= '0;
      yd2_q <= '0;
    end else begin
      case (uop_i.fin_dest)
        FD_XD1: xd1_q <= fin_i;
        FD_XD2: xd2_q <= fin_i;
        FD_YD1: yd1_q <= fin_i;
        FD_YD2: yd2_q <= fin_i;
        FD_DF1: begin
          yd1_q <= fin_i;
          yd2_q <= yd1_q;
          xd2_q <= xd1_q;
          xd1_q <= x_q;
        end
        FD_DF2: begin
          xd2_q <= xd1_q;
          xd1_q <= w_q;
        end
        default: ;
      endcase
    end
  end

  // Multiplier operand
  always_comb begin
    case (uop_i.data_sel)
      DS_X:    data_o = x_q;
      DS_W:    data_o = w_q;
      DS_Y:    data_o = y_q;
      DS_XD1:  data_o = xd1_q;
      DS_XD2:  data_o = xd2_q;
      DS_YD1:  data_o = yd1_q;
      DS_YD2:  data_o = yd2_q;
      default: data_o = x_q;
    endcase
  end

  // Filtered value, bypassed when it is rounded this cycle
  assign y_o = y_wr ? fin_i : y_q;

endmodule

FILE: rtl/biq_ctrl.sv
// Step sequencer and handshake control for the biquad filter.
module biq_ctrl
  import biq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [1:0] structure_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output biq_req_t   req_o,
  output biq_uop_t   uop_o
);

  logic              running_q, running_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  biq_uop_t          uop_raw;
  logic              out_blocked, fire, accept;

  // Decode the current step; hold the final step while the result reg is full and stalled
  always_comb begin
    uop_raw     = biq_ucode(structure_i, step_q);
    out_blocked = out_valid_q && out_stall_i;
    fire        = running_q && !(uop_raw.last && out_blocked);
    uop_o       = uop_raw;
    if (!fire) begin
      uop_o.acc_op   = AC_NONE;
      uop_o.fin_dest = FD_NONE;
      uop_o.last     = 1'b0;
    end
  end

  // Input transfer
  assign accept      = in_valid_i && !running_q;
  assign in_stall_o  = running_q;
  assign req_o.load  = accept && (op_i == OP_SAMPLE);
  assign req_o.clear = accept && (op_i == OP_CLEAR);

  // Sequencer next state
  always_comb begin
    running_d = running_q;
    step_d    = step_q;
    if (req_o.load) begin
      running_d = 1'b1;
      step_d    = '0;
    end else if (fire) begin
      if (uop_raw.last) begin
        running_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    out_valid_d = uop_o.last || out_blocked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_last_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uop_o.last |=> out_valid_q)
    else $error("final step did not present a result");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.load |=> (running_q && step_q == '0))
    else $error("sample transfer did not start the program at step zero");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.clear |=> !running_q)
    else $error("clear command started the sequencer");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (step_q <= STEP_MAX))
    else $error("step counter ran past the longest program");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> out_valid_q)
    else $error("program ended without a pending result");

endmodule

FILE: rtl/biquad_iir_four_structures_top.sv
// Biquad IIR filter top level: config registers, shared MAC, sequencer, output reg.
// Sample path: a sample transfer starts the structure's microcode program, run one step
//   per cycle, unless the final step is held by a stalled result, on a single shared
//   multiplier and accumulator. A clear transfer zeroes the delay registers.
// Input: no new item is taken while a program runs; one unit does all work.
// Reset: asynchronous, active low; delay registers and coefficients to zero, structure 3.
module biquad_iir_four_structures_top
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
    {{(COEF_WIDTH-1){1'b0}}, 1'b1} << (COEF_WIDTH - 3);
  localparam logic signed [STATE_W-1:0] SMP_MAX =
    {1'b0, {(STATE_W-1){1'b1}}} >> (STATE_W - SAMPLE_WIDTH);
  localparam logic signed [STATE_W-1:0] SMP_MIN = ~SMP_MAX;

  logic [1:0]                     structure_q;
  logic signed [COEF_WIDTH-1:0]   a0_q, a1_q, a2_q, b1_q, b2_q;
  logic signed [COEF_WIDTH-1:0]   coef;
  logic signed [STATE_W-1:0]      data, fin, y_cur;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q, sample_out_d;
  biq_req_t                       req;
  biq_uop_t                       uop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      structure_q <= STRUCT_RESET;
      a0_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRUCTURE: structure_q <= cfg_data_i[1:0];
        CFG_A0:        a0_q <= cfg_data_i;
        CFG_A1:        a1_q <= cfg_data_i;
        CFG_A2:        a2_q <= cfg_data_i;
        CFG_B1:        b1_q <= cfg_data_i;
        CFG_B2:        b2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficient operand
  always_comb begin
    case (uop.coef_sel)
      CS_A0:   coef = a0_q;
      CS_A1:   coef = a1_q;
      CS_A2:   coef = a2_q;
      CS_B1:   coef = b1_q;
      CS_B2:   coef = b2_q;
      default: coef = COEF_ONE;
    endcase
  end

  biq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .structure_i (structure_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .req_o       (req),
    .uop_o       (uop)
  );

  biq_state #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .sample_i (sample_in_i),
    .uop_i    (uop),
    .fin_i    (fin),
    .data_o   (data),
    .y_o      (y_cur)
  );

  biq_mac #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .coef_i   (coef),
    .data_i   (data),
    .acc_op_i (uop.acc_op),
    .fin_o    (fin)
  );

  // Output saturation and result register
  always_comb begin
    if (y_cur > SMP_MAX) begin
      sample_out_d = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_cur < SMP_MIN) begin
      sample_out_d = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      sample_out_d = y_cur[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop.last) begin
      sample_out_q <= sample_out_d;
    end
  end

  assign sample_out_o = sample_out_q;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the four-structure biquad filter: table-driven and random stimulus.
`timescale 1ns / 100ps

module tb;
  import biq_pkg::*;

  localparam int SMP_W  = 24;
  localparam int COEF_W = 24;
  localparam int FRAC   = COEF_W - 3;

  // Unused register slots; writes there must leave the filter alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  localparam logic [COEF_W-1:0] Q_ONE = 24'h200000;
  localparam logic [COEF_W-1:0] Q_MAX = 24'h7FFFFF;
  localparam logic [COEF_W-1:0] Q_MIN = 24'h800000;
  localparam logic signed [SMP_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SMP_W-1:0] S_MIN = 24'sh800000;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

  localparam int N_PHASES        = 24;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int HOLD_PHASE      = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 16;

  typedef enum int {ROW_REG, ROW_ITEM} row_kind_e;
  typedef enum int {GS_RANDOM, GS_TAME, GS_ALL_MAX, GS_ALL_MIN, GS_CORNERS, GS_FIR} gain_style_e;
  typedef enum int {FEED_FWD, FEED_B1, FEED_B2} gain_role_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [COEF_W-1:0]        data;
    logic                     op;
    logic signed [SMP_W-1:0]  smp;
    bit                       has_want;
    logic signed [SMP_W-1:0]  want;
  } dir_row_t;

  // DUT ports
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = CFG_STRUCTURE;
  logic [COEF_W-1:0]       cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic                    op_i        = OP_SAMPLE;
  logic signed [SMP_W-1:0] sample_in_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [SMP_W-1:0] sample_out_o;

  // Bench state
  bit                      cur_has_want = 1'b0;
  logic signed [SMP_W-1:0] cur_want     = '0;
  bit                      hold_out     = 1'b0;
  int                      gap_pct      = 20;
  int                      stall_pct    = 20;
  int                      fail_count   = 0;
  logic signed [SMP_W-1:0] filtered_q [$];

  // Filter model: structure, gains and delay line
  logic [1:0] flt_struct;
  longint     gain_a0, gain_a1, gain_a2, gain_b1, gain_b2;
  longint     x_hist1, x_hist2, y_hist1, y_hist2;

  // Directed table: reset behavior, gain extremes, each structure, clear, spare slots
  dir_row_t dir_rows [36] = '{
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MAX, 1'b1, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MIN, 1'b1, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_CLEAR, 24'sh5A5A5A, 1'b0, '0},
    '{ROW_REG,  CFG_A0, Q_ONE, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MAX, 1'b1, S_MAX},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MIN, 1'b1, S_MIN},
    '{ROW_REG,  CFG_A0, Q_MAX, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MAX, 1'b1, S_MAX},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MIN, 1'b1, S_MIN},
    '{ROW_REG,  CFG_A0, Q_MIN, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MAX, 1'b1, S_MIN},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MIN, 1'b1, S_MAX},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, '0, 1'b1, '0},
    '{ROW_REG,  CFG_A0, 24'h040000, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_REG,  CFG_A1, 24'h080000, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_REG,  CFG_A2, 24'h040000, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_REG,  CFG_B1, 24'hD00000, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_REG,  CFG_B2, 24'h147AE1, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_REG,  CFG_STRUCTURE, {22'd0, ST_DF1}, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MAX, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, 24'sd1000, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, -24'sd1, 1'b0, '0},
    // structure switched with the delay line left as it is
    '{ROW_REG,  CFG_STRUCTURE, {22'd0, ST_DF2}, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, 24'sd12345, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MIN, 1'b0, '0},
    '{ROW_REG,  CFG_STRUCTURE, {22'd0, ST_TDF}, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, 24'sh123456, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, -24'sd77, 1'b0, '0},
    '{ROW_REG,  CFG_STRUCTURE, {22'd0, ST_TCF}, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, 24'sd42, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, S_MAX, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_CLEAR, S_MAX, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, 24'sd500, 1'b0, '0},
    '{ROW_REG,  CFG_SPARE6, 24'hFFFFFF, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_REG,  CFG_SPARE7, 24'h5A5A5A, OP_SAMPLE, '0, 1'b0, '0},
    '{ROW_ITEM, CFG_STRUCTURE, '0, OP_SAMPLE, 24'sd777, 1'b0, '0}
  };

  biquad_iir_four_structures_top #(
    .SAMPLE_WIDTH(SMP_W),
    .COEF_WIDTH  (COEF_W)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Saturate to a signed width
  function automatic longint clamp_bits(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Accumulator add/subtract, saturating at the 64-bit range
  function automatic longint acc_add(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? ACC_MIN : ACC_MAX;
    return s[63:0];
  endfunction

  function automatic longint acc_sub(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? ACC_MIN : ACC_MAX;
    return s[63:0];
  endfunction

  // Round half up out of coefficient scale, saturate to state width
  function automatic longint round_to_state(longint acc);
    longint r;
    r = acc_add(acc, 64'sd1 <<< (FRAC - 1));
    return clamp_bits(r >>> FRAC, STATE_W);
  endfunction

  // Plain term brought to coefficient scale
  function automatic longint unity_term(longint v);
    return v <<< FRAC;
  endfunction

  function automatic void reset_filter_model();
    flt_struct = STRUCT_RESET;
    gain_a0 = 0; gain_a1 = 0; gain_a2 = 0; gain_b1 = 0; gain_b2 = 0;
    x_hist1 = 0; x_hist2 = 0; y_hist1 = 0; y_hist2 = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    case (idx)
      CFG_STRUCTURE: flt_struct = data[1:0];
      CFG_A0:        gain_a0 = longint'(signed'(data));
      CFG_A1:        gain_a1 = longint'(signed'(data));
      CFG_A2:        gain_a2 = longint'(signed'(data));
      CFG_B1:        gain_b1 = longint'(signed'(data));
      CFG_B2:        gain_b2 = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  // One filtered sample under the current structure; advances the delay line
  function automatic logic signed [SMP_W-1:0] filter_sample(longint x);
    longint y;
    longint w;
    longint acc;
    case (flt_struct)
      ST_DF1: begin
        acc = gain_a0 * x;
        acc = acc_add(acc, gain_a1 * x_hist1);
        acc = acc_add(acc, gain_a2 * x_hist2);
        acc = acc_sub(acc, gain_b1 * y_hist1);
        acc = acc_sub(acc, gain_b2 * y_hist2);
        y = round_to_state(acc);
        x_hist2 = x_hist1;
        x_hist1 = x;
        y_hist2 = y_hist1;
        y_hist1 = y;
      end
      ST_DF2: begin
        acc = acc_sub(unity_term(x), gain_b1 * x_hist1);
        acc = acc_sub(acc, gain_b2 * x_hist2);
        w = round_to_state(acc);
        acc = acc_add(gain_a0 * w, gain_a1 * x_hist1);
        acc = acc_add(acc, gain_a2 * x_hist2);
        y = round_to_state(acc);
        x_hist2 = x_hist1;
        x_hist1 = w;
      end
      ST_TDF: begin
        w = clamp_bits(x + y_hist1, STATE_W);
        y = round_to_state(acc_add(gain_a0 * w, unity_term(x_hist1)));
        y_hist1 = round_to_state(acc_sub(unity_term(y_hist2), gain_b1 * w));
        y_hist2 = round_to_state(-(gain_b2 * w));
        x_hist1 = round_to_state(acc_add(unity_term(x_hist2), gain_a1 * w));
        x_hist2 = round_to_state(gain_a2 * w);
      end
      default: begin
        y = round_to_state(acc_add(gain_a0 * x, unity_term(x_hist1)));
        acc = acc_sub(gain_a1 * x, gain_b1 * y);
        x_hist1 = round_to_state(acc_add(acc, unity_term(x_hist2)));
        x_hist2 = round_to_state(acc_sub(gain_a2 * x, gain_b2 * y));
      end
    endcase
    return SMP_W'(clamp_bits(y, SMP_W));
  endfunction

  // Idle stretch: none, mostly short, now and then long
  function automatic int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          default: return -24'sd1;
        endcase
      end
      1, 2:    return SMP_W'($urandom_range(2000) - 1000);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_gain(gain_style_e style, gain_role_e role);
    case (style)
      GS_RANDOM:  return COEF_W'($urandom);
      GS_TAME: begin
        // modest gains, feedback kept near the stable region
        case (role)
          FEED_FWD: return COEF_W'($urandom_range(24'h200000) - 24'h100000);
          FEED_B1:  return COEF_W'($urandom_range(24'h780000) - 24'h3C0000);
          default:  return COEF_W'($urandom_range(24'h1CCCCC));
        endcase
      end
      GS_ALL_MAX: return Q_MAX;
      GS_ALL_MIN: return Q_MIN;
      GS_CORNERS: begin
        case ($urandom_range(4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      default:    return (role == FEED_FWD) ? COEF_W'($urandom) : '0;
    endcase
  endfunction

  // Config write, one clock wide
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic program_filter(logic [1:0] st, gain_style_e style);
    logic [COEF_W-1:0] sdata;
    sdata      = COEF_W'($urandom);
    sdata[1:0] = st;
    write_reg(CFG_STRUCTURE, sdata);
    write_reg(CFG_A0, pick_gain(style, FEED_FWD));
    write_reg(CFG_A1, pick_gain(style, FEED_FWD));
    write_reg(CFG_A2, pick_gain(style, FEED_FWD));
    write_reg(CFG_B1, pick_gain(style, FEED_B1));
    write_reg(CFG_B2, pick_gain(style, FEED_B2));
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE6 : CFG_SPARE7, COEF_W'($urandom));
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(logic op, logic signed [SMP_W-1:0] smp, bit has_want,
                           logic signed [SMP_W-1:0] want);
    int gap;
    @(negedge clk_i);
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    op_i         = op;
    sample_in_i  = smp;
    cur_has_want = has_want;
    cur_want     = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering, wait for all outputs, then let a trailing clear finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Track config writes and input transfers, check output transfers
  always @(posedge clk_i or negedge rst_ni) begin : track_filter
    logic signed [SMP_W-1:0] want;
    if (!rst_ni) begin
      reset_filter_model();
    end else begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("sample_out %0d with no sample pending", sample_out_o);
        end else begin
          want = filtered_q.pop_front();
          if (sample_out_o !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("sample_out mismatch: expected %0d, got %0d", want, sample_out_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (op_i == OP_CLEAR) begin
          x_hist1 = 0; x_hist2 = 0; y_hist1 = 0; y_hist2 = 0;
        end else begin
          want = filter_sample(longint'(sample_in_i));
          filtered_q.push_back(cur_has_want ? cur_want : want);
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int len;
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_out = 1'b0;
      end else begin
        len = idle_len(stall_pct);
        if (len > 0) begin
          out_stall_i = 1'b1;
          repeat (len - 1) @(negedge clk_i);
        end else begin
          out_stall_i = 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (int i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_REG) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].has_want, dir_rows[i].want);
      end
    end

    // random phases: every structure against every gain style
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph % 3)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 15; stall_pct = 15; end
        default: begin gap_pct = 45; stall_pct = 35; end
      endcase
      program_filter(2'(ph % 4), gain_style_e'((ph / 4) % 6));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // back up the output while the input keeps pushing
        if (ph == HOLD_PHASE && n == 10) hold_out = 1'b1;
        send_item(($urandom_range(19) == 0) ? OP_CLEAR : OP_SAMPLE, pick_sample(), 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
